// ----- design/gtfa_pkg.sv -----
package gtfa_pkg;

  localparam int TILE_ROWS_DEF = 4;
  localparam int TILE_COLS_DEF = 12;
  localparam int NFIELD_ROWS   = 4;
  localparam int ROW_W         = 2;
  localparam int COL_W         = 4;
  localparam int MODE_W        = 2;
  localparam int STEP_W        = 3;

  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS    = 64'h7FF0_0000_0000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_ACC  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD_WR,
    DP_RD,
    DP_STAGE,
    DP_OUT,
    DP_COPER,
    DP_SPEC,
    DP_MUL,
    DP_PLOAD,
    DP_NORM1,
    DP_ALIGN,
    DP_ADD,
    DP_FIX,
    DP_NORM2,
    DP_ROUND,
    DP_PACK,
    DP_RES_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [ROW_W-1:0]   row;
    logic [STEP_W-1:0]  step;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              col_ok;
    logic              special;
    logic              pq_norm;
    logic              r_zero;
    logic              r_norm;
  } dp_stat_t;

endpackage

// ----- design/gtfa_if.sv -----
interface gtfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  col;
  logic [63:0] a0;
  logic [63:0] a1;
  logic [63:0] a2;
  logic [63:0] a3;
  logic [63:0] b;
  logic [63:0] c0;
  logic [63:0] c1;
  logic [63:0] c2;
  logic [63:0] c3;

  modport source(output valid, mode, col, a0, a1, a2, a3, b, c0, c1, c2, c3, input ready);
  modport sink(input valid, mode, col, a0, a1, a2, a3, b, c0, c1, c2, c3, output ready);
endinterface

interface gtfa_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_col;
  logic [63:0] r0;
  logic [63:0] r1;
  logic [63:0] r2;
  logic [63:0] r3;

  modport source(output valid, out_col, r0, r1, r2, r3, input ready);
  modport sink(input valid, out_col, r0, r1, r2, r3, output ready);
endinterface

// ----- design/gtfa_dp.sv -----
module gtfa_dp #(
  parameter int TILE_ROWS = gtfa_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = gtfa_pkg::TILE_COLS_DEF
) (
  input  logic                  clk,
  input  gtfa_pkg::dp_cmd_t     cmd,
  output gtfa_pkg::dp_stat_t    stat,
  input  logic [1:0]            in_mode,
  input  logic [3:0]            in_col,
  input  logic [3:0][63:0]      in_a,
  input  logic [63:0]           in_b,
  input  logic [3:0][63:0]      in_c,
  output logic [3:0]            out_col,
  output logic [3:0][63:0]      out_r
);
  import gtfa_pkg::*;

  localparam int DEPTH  = TILE_ROWS * TILE_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata;
  logic [ADDR_W-1:0] addr;

  logic [1:0]       mode_q;
  logic [3:0]       col_q;
  logic [3:0][63:0] a_q;
  logic [63:0]      b_q;
  logic [3:0][63:0] cin_q;
  logic [3:0][63:0] stage;
  logic [63:0]      c_op;
  logic [63:0]      ao;

  logic [52:0]  ma, mb;
  logic [105:0] acc;
  logic [53:0]  preg;
  logic signed [12:0] ep, ec, ex, e_r;
  logic         sp, sc, czero, sr, eff_sub, r_zero;
  logic [125:0] p, q, x, y;
  logic [127:0] sum;
  logic [126:0] rn;
  logic [53:0]  mant;
  logic signed [13:0] unit;
  logic [63:0]  res;

  logic         spec;
  logic [63:0]  sval;
  logic         sa_c, sb_c, sc_c, sp_c;

  // alignment, rounding, packing and partial-product terms
  logic         swap;
  logic [125:0] yy;
  logic signed [13:0] dd;
  logic [6:0]   ash;
  logic [125:0] amask;
  logic         alost;
  logic [127:0] mag;
  logic signed [13:0] tt, rr;
  logic [7:0]   rsh;
  logic [127:0] rw, ru, rmask;
  logic         rstk, rinc;
  logic [53:0]  rm;
  logic [53:0]  m2;
  logic signed [13:0] un, bias;
  logic [26:0]  pa, pb;
  logic [1:0]   acc_sel;
  logic [105:0] addend;

  function automatic logic f_nan(logic [63:0] v);
    return (&v[62:52]) && (|v[51:0]);
  endfunction

  function automatic logic f_inf(logic [63:0] v);
    return v[62:0] == INF_BITS[62:0];
  endfunction

  function automatic logic f_zero(logic [63:0] v);
    return v[62:0] == 63'd0;
  endfunction

  function automatic logic signed [12:0] f_exp(logic [63:0] v);
    logic signed [12:0] e;
    if (v[62:52] == 11'd0) begin
      e = -13'sd1074;
    end else begin
      e = $signed({2'b00, v[62:52]}) - 13'sd1075;
    end
    return e;
  endfunction

  function automatic logic [52:0] f_mant(logic [63:0] v);
    return {(v[62:52] != 11'd0), v[51:0]};
  endfunction

  assign addr = ADDR_W'(int'(col_q) * TILE_ROWS + int'(cmd.row));
  assign ao   = a_q[cmd.row];

  // special operands: NaN, infinity and zero factors
  always_comb begin
    sa_c = ao[63];
    sb_c = b_q[63];
    sc_c = c_op[63];
    sp_c = sa_c ^ sb_c;
    spec = 1'b1;
    sval = 64'd0;
    if (f_nan(ao)) begin
      sval = ao | QUIET_BIT;
    end else if (f_nan(b_q)) begin
      sval = b_q | QUIET_BIT;
    end else if (f_nan(c_op)) begin
      sval = c_op | QUIET_BIT;
    end else if (f_inf(ao) || f_inf(b_q)) begin
      if (f_zero(ao) || f_zero(b_q)) begin
        sval = DEFAULT_NAN;
      end else if (f_inf(c_op) && (sc_c != sp_c)) begin
        sval = DEFAULT_NAN;
      end else begin
        sval = {sp_c, INF_BITS[62:0]};
      end
    end else if (f_inf(c_op)) begin
      sval = c_op;
    end else if (f_zero(ao) || f_zero(b_q)) begin
      if (f_zero(c_op)) begin
        sval = {(sp_c == sc_c) ? sp_c : 1'b0, 63'd0};
      end else begin
        sval = c_op;
      end
    end else begin
      spec = 1'b0;
    end
  end

  // partial products of the 53x53 significand multiply
  always_comb begin
    case (cmd.step[1:0])
      2'd0: begin
        pa = {1'b0, ma[25:0]};
        pb = {1'b0, mb[25:0]};
      end
      2'd1: begin
        pa = {1'b0, ma[25:0]};
        pb = mb[52:26];
      end
      2'd2: begin
        pa = ma[52:26];
        pb = {1'b0, mb[25:0]};
      end
      default: begin
        pa = ma[52:26];
        pb = mb[52:26];
      end
    endcase
    acc_sel = cmd.step[1:0] - 2'd1;
    case (acc_sel)
      2'd0:    addend = 106'(preg);
      2'd3:    addend = 106'(preg) << 52;
      default: addend = 106'(preg) << 26;
    endcase
  end

  // operand alignment
  always_comb begin
    swap  = ep < ec;
    yy    = swap ? p : q;
    dd    = swap ? (14'(ec) - 14'(ep)) : (14'(ep) - 14'(ec));
    ash   = (dd >= 14'sd126) ? 7'd126 : dd[6:0];
    amask = (126'(1) << ash) - 126'(1);
    alost = |(yy & amask);
    mag   = sum[127] ? (128'd0 - sum) : sum;
  end

  // rounding position and sticky
  always_comb begin
    tt    = -14'sd1074 - 14'(e_r);
    rr    = (tt > 14'sd74) ? tt : 14'sd74;
    rsh   = ((rr - 14'sd1) >= 14'sd128) ? 8'd128 : 8'(rr - 14'sd1);
    rw    = {1'b0, rn};
    ru    = rw >> rsh;
    rmask = (128'(1) << rsh) - 128'(1);
    rstk  = |(rw & rmask);
    rm    = ru[54:1];
    rinc  = ru[0] & (rstk | rm[0]);
  end

  always_comb begin
    m2   = mant[53] ? (mant >> 1) : mant;
    un   = mant[53] ? (unit + 14'sd1) : unit;
    bias = un + 14'sd1075;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        mode_q <= in_mode;
        col_q  <= in_col;
        a_q    <= in_a;
        b_q    <= in_b;
        cin_q  <= in_c;
        stage  <= '0;
      end
      DP_LOAD_WR: mem[addr] <= cin_q[cmd.row];
      DP_RES_WR:  mem[addr] <= res;
      DP_RD:      rdata <= mem[addr];
      DP_STAGE:   stage[cmd.row] <= rdata;
      DP_OUT: begin
        out_col <= col_q;
        out_r   <= stage;
      end
      DP_COPER:   c_op <= rdata;
      DP_SPEC: begin
        res   <= sval;
        ma    <= f_mant(ao);
        mb    <= f_mant(b_q);
        ep    <= f_exp(ao) + f_exp(b_q);
        ec    <= f_exp(c_op);
        sp    <= sp_c;
        sc    <= sc_c;
        czero <= f_zero(c_op);
        q     <= 126'(f_mant(c_op));
        acc   <= '0;
      end
      DP_MUL: begin
        if (cmd.step < 3'd4) begin
          preg <= 54'(pa) * 54'(pb);
        end
        if (cmd.step != 3'd0) begin
          acc <= acc + addend;
        end
      end
      DP_PLOAD: p <= {20'd0, acc};
      DP_NORM1: begin
        if (!p[125]) begin
          if (p[125:110] == 16'd0) begin
            p  <= p << 16;
            ep <= ep - 13'sd16;
          end else begin
            p  <= p << 1;
            ep <= ep - 13'sd1;
          end
        end
        if (!czero && !q[125]) begin
          if (q[125:110] == 16'd0) begin
            q  <= q << 16;
            ec <= ec - 13'sd16;
          end else begin
            q  <= q << 1;
            ec <= ec - 13'sd1;
          end
        end
      end
      DP_ALIGN: begin
        if (czero) begin
          x       <= p;
          y       <= '0;
          ex      <= ep;
          sr      <= sp;
          eff_sub <= 1'b0;
        end else begin
          x       <= swap ? q : p;
          y       <= (yy >> ash) | 126'(alost);
          ex      <= swap ? ec : ep;
          sr      <= swap ? sc : sp;
          eff_sub <= sp != sc;
        end
      end
      DP_ADD: begin
        if (eff_sub) begin
          sum <= {2'b00, x} - {2'b00, y};
        end else begin
          sum <= {2'b00, x} + {2'b00, y};
        end
      end
      DP_FIX: begin
        rn     <= mag[126:0];
        e_r    <= ex;
        r_zero <= sum == 128'd0;
        if (sum[127]) begin
          sr <= ~sr;
        end
        if (sum == 128'd0) begin
          res <= 64'd0;
        end
      end
      DP_NORM2: begin
        if (!rn[126]) begin
          if (rn[126:111] == 16'd0) begin
            rn  <= rn << 16;
            e_r <= e_r - 13'sd16;
          end else begin
            rn  <= rn << 1;
            e_r <= e_r - 13'sd1;
          end
        end
      end
      DP_ROUND: begin
        mant <= rm + 54'(rinc);
        unit <= 14'(e_r) + rr;
      end
      DP_PACK: begin
        if (m2[52]) begin
          if (bias >= 14'sd2047) begin
            res <= {sr, INF_BITS[62:0]};
          end else begin
            res <= {sr, bias[10:0], m2[51:0]};
          end
        end else begin
          res <= {sr, 11'd0, m2[51:0]};
        end
      end
      default: ;
    endcase
  end

  assign stat.mode    = mode_q;
  assign stat.col_ok  = int'(col_q) < TILE_COLS;
  assign stat.special = spec;
  assign stat.pq_norm = p[125] && (czero || q[125]);
  assign stat.r_zero  = r_zero;
  assign stat.r_norm  = rn[126];

endmodule

// ----- design/gtfa_ctrl.sv -----
module gtfa_ctrl #(
  parameter int LIVE_ROWS = gtfa_pkg::NFIELD_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  gtfa_pkg::dp_stat_t stat,
  output gtfa_pkg::dp_cmd_t  cmd
);
  import gtfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD_WR, S_RD_ISSUE, S_RD_CAP, S_OUT_WAIT,
    S_F_RD, S_F_OPER, S_F_SPEC, S_F_MUL, S_F_PLOAD, S_F_NORM1, S_F_ALIGN,
    S_F_ADD, S_F_FIX, S_F_NORM2, S_F_ROUND, S_F_PACK, S_F_WR
  } state_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LIVE_ROWS - 1);

  state_t            state;
  logic [ROW_W-1:0]  row;
  logic [STEP_W-1:0] step;
  logic              out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.row  = row;
    cmd.step = step;
    case (state)
      S_IDLE:     cmd.op = in_valid ? DP_CAPTURE : DP_NOP;
      S_LOAD_WR:  cmd.op = DP_LOAD_WR;
      S_RD_ISSUE: cmd.op = DP_RD;
      S_RD_CAP:   cmd.op = DP_STAGE;
      S_OUT_WAIT: cmd.op = out_free ? DP_OUT : DP_NOP;
      S_F_RD:     cmd.op = DP_RD;
      S_F_OPER:   cmd.op = DP_COPER;
      S_F_SPEC:   cmd.op = DP_SPEC;
      S_F_MUL:    cmd.op = DP_MUL;
      S_F_PLOAD:  cmd.op = DP_PLOAD;
      S_F_NORM1:  cmd.op = DP_NORM1;
      S_F_ALIGN:  cmd.op = DP_ALIGN;
      S_F_ADD:    cmd.op = DP_ADD;
      S_F_FIX:    cmd.op = DP_FIX;
      S_F_NORM2:  cmd.op = DP_NORM2;
      S_F_ROUND:  cmd.op = DP_ROUND;
      S_F_PACK:   cmd.op = DP_PACK;
      S_F_WR:     cmd.op = DP_RES_WR;
      default:    cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once the sink takes the beat, unless a new one replaces it
      if (out_valid && out_ready && state != S_OUT_WAIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          row <= '0;
          case (stat.mode)
            MODE_LOAD: state <= stat.col_ok ? S_LOAD_WR : S_IDLE;
            MODE_ACC:  state <= stat.col_ok ? S_F_RD : S_IDLE;
            MODE_READ: state <= stat.col_ok ? S_RD_ISSUE : S_OUT_WAIT;
            default:   state <= S_IDLE;
          endcase
        end
        S_LOAD_WR: begin
          if (row == LAST_ROW) begin
            state <= S_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        S_RD_ISSUE: state <= S_RD_CAP;
        S_RD_CAP: begin
          if (row == LAST_ROW) begin
            state <= S_OUT_WAIT;
          end else begin
            row   <= row + 1'b1;
            state <= S_RD_ISSUE;
          end
        end
        S_OUT_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_F_RD:   state <= S_F_OPER;
        S_F_OPER: state <= S_F_SPEC;
        S_F_SPEC: begin
          step  <= '0;
          state <= stat.special ? S_F_WR : S_F_MUL;
        end
        S_F_MUL: begin
          if (step == 3'd4) begin
            state <= S_F_PLOAD;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_F_PLOAD: state <= S_F_NORM1;
        S_F_NORM1: begin
          if (stat.pq_norm) begin
            state <= S_F_ALIGN;
          end
        end
        S_F_ALIGN: state <= S_F_ADD;
        S_F_ADD:   state <= S_F_FIX;
        S_F_FIX:   state <= S_F_NORM2;
        S_F_NORM2: begin
          if (stat.r_zero) begin
            state <= S_F_WR;
          end else if (stat.r_norm) begin
            state <= S_F_ROUND;
          end
        end
        S_F_ROUND: state <= S_F_PACK;
        S_F_PACK:  state <= S_F_WR;
        S_F_WR: begin
          if (row == LAST_ROW) begin
            state <= S_IDLE;
          end else begin
            row   <= row + 1'b1;
            state <= S_F_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_LOAD_WR || cmd.op == DP_RES_WR) |-> stat.col_ok)
    else $error("tile write to a column outside the tile");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_OUT) |-> out_free)
    else $error("result overwritten while still held");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted beat not dispatched");

  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT_WAIT))
    else $error("result raised outside the output step");
`endif

endmodule

// ----- design/gemm_tile_fma_accumulator.sv -----
// 4x12 double-precision GEMM tile accumulator.
// in_ch carries one beat per item: mode selects load column (c0..c3 into
// column col), accumulate (c[row] = fma(a_row, b, c[row]), one rounding,
// round to nearest even) or read column. Only read items produce a beat
// on out_ch (out_col, r0..r3); a read of a column outside the tile
// returns zeros. Mode 3 is dropped.
// Items are handled one at a time; in_ch.ready is high only when idle.
// Load writes c0..c3 into the column row by row. Read stages the column
// row by row and then moves it to the result register (a column outside
// the tile goes straight there). Accumulate: each row runs through one
// shared FMA sequencer (tile read, special-case check, four 27x27 partial
// products, normalize, align, add, sign fix, normalize, round, pack,
// write). A row settled by a special operand skips to the write; on other
// rows each normalize step repeats until its operands are normalized.
// A finished read waits in the output register; the block still accepts
// the next item, and a later read stalls only in its final step until
// the held beat is taken. Reset clears control only; tile contents are
// undefined until loaded.
module gemm_tile_fma_accumulator #(
  parameter int TILE_ROWS = gtfa_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = gtfa_pkg::TILE_COLS_DEF
) (
  input logic         clk,
  input logic         rst,
  gtfa_in_if.sink     in_ch,
  gtfa_out_if.source  out_ch
);
  import gtfa_pkg::*;

  // rows beyond the four input fields are never reached
  localparam int LIVE_ROWS = (TILE_ROWS < NFIELD_ROWS) ? TILE_ROWS : NFIELD_ROWS;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [3:0][63:0] a_vec;
  logic [3:0][63:0] c_vec;
  logic [3:0][63:0] r_vec;

  assign a_vec = {in_ch.a3, in_ch.a2, in_ch.a1, in_ch.a0};
  assign c_vec = {in_ch.c3, in_ch.c2, in_ch.c1, in_ch.c0};

  assign out_ch.r0 = r_vec[0];
  assign out_ch.r1 = r_vec[1];
  assign out_ch.r2 = r_vec[2];
  assign out_ch.r3 = r_vec[3];

  gtfa_ctrl #(
    .LIVE_ROWS(LIVE_ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtfa_dp #(
    .TILE_ROWS(TILE_ROWS),
    .TILE_COLS(TILE_COLS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .stat   (stat),
    .in_mode(in_ch.mode),
    .in_col (in_ch.col),
    .in_a   (a_vec),
    .in_b   (in_ch.b),
    .in_c   (c_vec),
    .out_col(out_ch.out_col),
    .out_r  (r_vec)
  );

endmodule
